// ----- sv/ffd_pkg.sv -----
package ffd_pkg;

   // Default trig resolution, entries per turn
   localparam int DEF_SINE_ENTRIES = 1024;

   // Pipeline latencies of the sub-units, in cycles
   localparam int PHASE_LAT = 4;
   localparam int TRIG_LAT = 7;
   localparam int SUM_LAT = 7;
   localparam int ARG_DELAY = PHASE_LAT + TRIG_LAT;

   // Sine series coefficients, Q30
   localparam logic [30:0] S1 = 31'((64'd1570796327 << 30) / 64'd1000000000);
   localparam logic [30:0] S3 = 31'((64'd645964098 << 30) / 64'd1000000000);
   localparam logic [30:0] S5 = 31'((64'd79692626 << 30) / 64'd1000000000);
   localparam logic [30:0] S7 = 31'((64'd4681754 << 30) / 64'd1000000000);
   localparam logic [30:0] S9 = 31'((64'd160441 << 30) / 64'd1000000000);

   // Folded output gain per joint, Q32
   localparam longint unsigned K1_SH = (64'd64177824 << 32) / (64'd35040 * 64'd144);
   localparam longint unsigned K1_EL = (64'd64177824 << 32) / (64'd35040 * 64'd96);
   // Back-EMF gain per joint, Q24
   localparam longint unsigned K2_SH =
      ((64'd158856 * 64'd48 * 64'd144) << 24) / 64'd10000000;
   localparam longint unsigned K2_EL =
      ((64'd158856 * 64'd48 * 64'd96) << 24) / 64'd10000000;

   // Physical constants, Q24
   localparam longint unsigned XA_SH = ((64'd21347 << 24) / 64'd10000)
      + (((64'd144 * 64'd144 * 64'd57904) << 24) / 64'd10000000000);
   localparam longint unsigned XA_EL = ((64'd12328 << 24) / 64'd10000)
      + (((64'd96 * 64'd96 * 64'd57904) << 24) / 64'd10000000000);
   localparam longint unsigned XCOS = (64'd19865 << 24) / 64'd10000;
   localparam longint unsigned XM = (64'd12328 << 24) / 64'd10000;
   localparam longint unsigned XH = (64'd99326 << 24) / 64'd100000;
   localparam longint unsigned XB_SH = ((64'd144 * 64'd144 * 64'd3716) << 24) / 64'd1000000000;
   localparam longint unsigned XB_EL = ((64'd96 * 64'd96 * 64'd3716) << 24) / 64'd1000000000;
   localparam longint unsigned XF_SH = ((64'd144 * 64'd404055) << 24) / 64'd100000000;
   localparam longint unsigned XF_EL = ((64'd96 * 64'd404055) << 24) / 64'd100000000;

   // Term weights, all scaled to land in Q44 effort counts
   localparam longint SH_A1 = longint'((XA_SH * K1_SH) >> 20);
   localparam longint SH_A1C = longint'((XCOS * K1_SH) >> 36);
   localparam longint SH_A2 = longint'((XM * K1_SH) >> 20);
   localparam longint SH_A2C = longint'((XH * K1_SH) >> 36);
   localparam longint SH_VEL = longint'(((XB_SH * K1_SH) >> 22) + (K2_SH << 10));
   localparam longint SH_FRIC = longint'((XF_SH * K1_SH) >> 12);
   localparam longint SH_SIN = longint'((XH * K1_SH) >> 32);
   localparam longint SH_SIN2 = 2 * SH_SIN;
   localparam longint EL_A1 = longint'((XM * K1_EL) >> 20);
   localparam longint EL_A1C = longint'((XH * K1_EL) >> 36);
   localparam longint EL_A2 = longint'((XA_EL * K1_EL) >> 20);
   localparam longint EL_VEL = longint'(((XB_EL * K1_EL) >> 22) + (K2_EL << 10));
   localparam longint EL_FRIC = longint'((XF_EL * K1_EL) >> 12);
   localparam longint EL_SIN = longint'((XH * K1_EL) >> 32);

   // Command arguments carried alongside the angle path
   typedef struct packed {
      logic signed [15:0] w1;
      logic signed [15:0] w2;
      logic signed [15:0] a1;
      logic signed [15:0] a2;
   } arg_type;

endpackage

// ----- sv/ffd_phase.sv -----
// Maps the binary phase to the table angle in Q32 turns:
// k = phase*N >> 16, u = floor(k * 2^32 / N) by reciprocal and one correction.
module ffd_phase #(
   parameter int SINE_TABLE_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        valid_in,
   input  logic [15:0] phase_in,
   output logic        valid_out,
   output logic [31:0] angle_out
);
   import ffd_pkg::*;

   localparam int KW = $clog2(SINE_TABLE_ENTRIES);
   localparam logic [16:0] NCONST = 17'(SINE_TABLE_ENTRIES);
   localparam logic [47:0] RECIP = 48'((64'd1 << 48) / SINE_TABLE_ENTRIES);

   logic [3:0]    valid_ff;
   logic [KW-1:0] k1_ff, k2_ff, k3_ff;
   logic [31:0]   q2_ff, q3_ff;
   logic [48:0]   prod3_ff;
   logic [31:0]   angle_ff;
   logic [32:0]   kprod;
   logic [63:0]   qprod;
   logic [47:0]   rem;

   // valid shift
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], valid_in};
      end
   end

   assign kprod = 33'(phase_in) * 33'(NCONST);
   assign qprod = 64'(k1_ff) * 64'(RECIP);
   assign rem = ({16'(k3_ff), 32'd0}) - prod3_ff[47:0];

   // index, quotient estimate, back-multiply, correction
   always_ff @(posedge clock) begin
      k1_ff <= kprod[16 +: KW];
      k2_ff <= k1_ff;
      q2_ff <= qprod[47:16];
      k3_ff <= k2_ff;
      q3_ff <= q2_ff;
      prod3_ff <= 49'(q2_ff) * 49'(NCONST);
      angle_ff <= (rem >= 48'(NCONST)) ? q3_ff + 32'd1 : q3_ff;
   end

   assign valid_out = valid_ff[3];
   assign angle_out = angle_ff;

endmodule

// ----- sv/ffd_trig.sv -----
// Sine of an angle in Q32 turns, Q16 result; quadrant fold, Horner series.
module ffd_trig (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_in,
   input  logic [31:0]        angle_in,
   output logic               valid_out,
   output logic signed [17:0] sine_out
);
   import ffd_pkg::*;

   localparam logic [30:0] COEF [4] = '{S7, S5, S3, S1};

   logic [6:0]  valid_ff;
   logic [30:0] r_ff [5];
   logic [30:0] f2_ff [5];
   logic        neg_ff [6];
   logic [30:0] p_ff [4];
   logic [31:0] rp_ff;
   logic signed [17:0] sine_ff;
   logic [30:0] r_in;
   logic [61:0] rsq;
   logic [61:0] rpp;
   logic [17:0] s_round;
   logic [17:0] s_clamp;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[5:0], valid_in};
      end
   end

   // fold to the first quadrant, square
   assign r_in = angle_in[30] ? 31'h4000_0000 - {1'b0, angle_in[29:0]}
                              : {1'b0, angle_in[29:0]};
   assign rsq = 62'(r_in) * 62'(r_in);

   always_ff @(posedge clock) begin
      r_ff[0] <= r_in;
      f2_ff[0] <= rsq[60:30];
      neg_ff[0] <= angle_in[31];
   end

   // Horner steps, one multiply per stage
   for (genvar j = 0; j < 4; j++) begin : g_horner
      logic [30:0] prev;
      logic [61:0] prod;
      if (j == 0) begin : g_first
         assign prev = S9;
      end else begin : g_next
         assign prev = p_ff[j-1];
      end
      assign prod = 62'(f2_ff[j]) * 62'(prev);
      always_ff @(posedge clock) begin
         p_ff[j] <= COEF[j] - prod[60:30];
         r_ff[j+1] <= r_ff[j];
         neg_ff[j+1] <= neg_ff[j];
         if (j < 3) begin
            f2_ff[j+1] <= f2_ff[j];
         end
      end
   end

   // final product
   assign rpp = 62'(r_ff[4]) * 62'(p_ff[3]);
   always_ff @(posedge clock) begin
      rp_ff <= rpp[61:30];
      neg_ff[5] <= neg_ff[4];
   end

   // round to Q16, clamp, sign by half turn
   assign s_round = 18'((33'(rp_ff) + 33'd8192) >> 14);
   assign s_clamp = (s_round > 18'd65536) ? 18'd65536 : s_round;
   always_ff @(posedge clock) begin
      sine_ff <= neg_ff[5] ? -$signed(s_clamp) : $signed(s_clamp);
   end

   assign valid_out = valid_ff[6];
   assign sine_out = sine_ff;

endmodule

// ----- sv/ffd_sum.sv -----
// Dynamics terms, weighted sum and saturation to 16-bit drives.
module ffd_sum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_in,
   input  logic signed [17:0]    sine_in,
   input  logic signed [17:0]    cosine_in,
   input  ffd_pkg::arg_type      arg_in,
   output logic                  valid_out,
   output logic signed [15:0]    shoulder_out,
   output logic signed [15:0]    elbow_out,
   output logic                  clipped_out
);
   import ffd_pkg::*;

   logic [6:0] valid_ff;
   // stage 1
   arg_type arg1_ff, arg2_ff, arg3_ff;
   logic signed [17:0] sn1_ff;
   logic signed [31:0] w12_ff, w22_ff, w11_ff;
   logic signed [33:0] ca1_ff, ca2_ff, ca1b_ff, ca2b_ff, ca1c_ff, ca2c_ff;
   // stage 2
   logic signed [49:0] x12_ff, x22_ff, x11_ff;
   // stage 3
   logic signed [33:0] p12_ff, p22_ff, p11_ff;
   // stage 4
   logic signed [63:0] tsh_ff [8];
   logic signed [63:0] tel_ff [6];
   // stage 5, 6
   logic signed [63:0] sh_a_ff, sh_b_ff, el_a_ff, el_b_ff;
   logic signed [63:0] acc_sh_ff, acc_el_ff;
   // stage 7
   logic signed [15:0] sh_ff, el_ff;
   logic               clip_ff;

   logic signed [63:0] fric_sh, fric_el;
   logic signed [19:0] d_sh, d_el;
   logic               sat_sh_hi, sat_sh_lo, sat_el_hi, sat_el_lo;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[5:0], valid_in};
      end
   end

   // velocity pairs and cosine products
   always_ff @(posedge clock) begin
      arg1_ff <= arg_in;
      sn1_ff <= sine_in;
      w12_ff <= 32'(arg_in.w1) * 32'(arg_in.w2);
      w22_ff <= 32'(arg_in.w2) * 32'(arg_in.w2);
      w11_ff <= 32'(arg_in.w1) * 32'(arg_in.w1);
      ca1_ff <= 34'(cosine_in) * 34'(arg_in.a1);
      ca2_ff <= 34'(cosine_in) * 34'(arg_in.a2);
   end

   // times sine
   always_ff @(posedge clock) begin
      arg2_ff <= arg1_ff;
      ca1b_ff <= ca1_ff;
      ca2b_ff <= ca2_ff;
      x12_ff <= 50'(w12_ff) * 50'(sn1_ff);
      x22_ff <= 50'(w22_ff) * 50'(sn1_ff);
      x11_ff <= 50'(w11_ff) * 50'(sn1_ff);
   end

   // divide by 2^16 toward zero
   always_ff @(posedge clock) begin
      arg3_ff <= arg2_ff;
      ca1c_ff <= ca1b_ff;
      ca2c_ff <= ca2b_ff;
      p12_ff <= 34'((x12_ff + (x12_ff[49] ? 50'sd65535 : 50'sd0)) >>> 16);
      p22_ff <= 34'((x22_ff + (x22_ff[49] ? 50'sd65535 : 50'sd0)) >>> 16);
      p11_ff <= 34'((x11_ff + (x11_ff[49] ? 50'sd65535 : 50'sd0)) >>> 16);
   end

   // Coulomb friction by true sign of speed
   always_comb begin
      if (arg3_ff.w1 > 16'sd0) begin
         fric_sh = SH_FRIC;
      end else if (arg3_ff.w1 < 16'sd0) begin
         fric_sh = -SH_FRIC;
      end else begin
         fric_sh = '0;
      end
      if (arg3_ff.w2 > 16'sd0) begin
         fric_el = EL_FRIC;
      end else if (arg3_ff.w2 < 16'sd0) begin
         fric_el = -EL_FRIC;
      end else begin
         fric_el = '0;
      end
   end

   // weighted terms
   always_ff @(posedge clock) begin
      tsh_ff[0] <= SH_A1 * 64'(arg3_ff.a1);
      tsh_ff[1] <= SH_A1C * 64'(ca1c_ff);
      tsh_ff[2] <= SH_A2 * 64'(arg3_ff.a2);
      tsh_ff[3] <= SH_A2C * 64'(ca2c_ff);
      tsh_ff[4] <= SH_VEL * 64'(arg3_ff.w1);
      tsh_ff[5] <= fric_sh;
      tsh_ff[6] <= -(SH_SIN2 * 64'(p12_ff));
      tsh_ff[7] <= -(SH_SIN * 64'(p22_ff));
      tel_ff[0] <= EL_A1 * 64'(arg3_ff.a1);
      tel_ff[1] <= EL_A1C * 64'(ca1c_ff);
      tel_ff[2] <= EL_A2 * 64'(arg3_ff.a2);
      tel_ff[3] <= EL_VEL * 64'(arg3_ff.w2);
      tel_ff[4] <= fric_el;
      tel_ff[5] <= EL_SIN * 64'(p11_ff);
   end

   // two-level sum
   always_ff @(posedge clock) begin
      sh_a_ff <= tsh_ff[0] + tsh_ff[1] + tsh_ff[2] + tsh_ff[3];
      sh_b_ff <= tsh_ff[4] + tsh_ff[5] + tsh_ff[6] + tsh_ff[7];
      el_a_ff <= tel_ff[0] + tel_ff[1] + tel_ff[2];
      el_b_ff <= tel_ff[3] + tel_ff[4] + tel_ff[5];
      acc_sh_ff <= sh_a_ff + sh_b_ff;
      acc_el_ff <= el_a_ff + el_b_ff;
   end

   // scale out of Q44 toward zero, saturate
   assign d_sh = 20'((acc_sh_ff + (acc_sh_ff[63] ? 64'sh0FFF_FFFF_FFFF : 64'sd0)) >>> 44);
   assign d_el = 20'((acc_el_ff + (acc_el_ff[63] ? 64'sh0FFF_FFFF_FFFF : 64'sd0)) >>> 44);
   assign sat_sh_hi = d_sh > 20'sd32767;
   assign sat_sh_lo = d_sh < -20'sd32768;
   assign sat_el_hi = d_el > 20'sd32767;
   assign sat_el_lo = d_el < -20'sd32768;

   always_ff @(posedge clock) begin
      sh_ff <= sat_sh_hi ? 16'sh7FFF : (sat_sh_lo ? 16'sh8000 : d_sh[15:0]);
      el_ff <= sat_el_hi ? 16'sh7FFF : (sat_el_lo ? 16'sh8000 : d_el[15:0]);
      clip_ff <= sat_sh_hi | sat_sh_lo | sat_el_hi | sat_el_lo;
   end

   assign valid_out = valid_ff[6];
   assign shoulder_out = sh_ff;
   assign elbow_out = el_ff;
   assign clipped_out = clip_ff;

endmodule

// ----- sv/two_link_arm_feedforward_drive.sv -----
// Channel      Handshake             Payload
// request      start / busy          elbow angle, two velocities, two accelerations
// response     rsp_valid (strobe)    shoulder drive, elbow drive, clipped
//
// One transaction per cycle; busy is never raised.
// The pipeline runs from the input register through the phase-to-angle divide,
// the sine series (six dependent multiplies, one per stage), and the terms and sum.
// Synchronous reset clears only the valid bits; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
module two_link_arm_feedforward_drive #(
   parameter int SINE_TABLE_ENTRIES = ffd_pkg::DEF_SINE_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_elbow_angle_phase,
   input  logic signed [15:0] req_shoulder_velocity,
   input  logic signed [15:0] req_elbow_velocity,
   input  logic signed [15:0] req_shoulder_acceleration,
   input  logic signed [15:0] req_elbow_acceleration,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_shoulder_drive,
   output logic signed [15:0] rsp_elbow_drive,
   output logic               rsp_clipped
);
   import ffd_pkg::*;

   logic        valid0_ff;
   logic [15:0] phase0_ff;
   arg_type     arg_ff [ARG_DELAY+1];
   logic        angle_valid;
   logic [31:0] angle;
   logic        sin_valid, cos_valid;
   logic signed [17:0] sine, cosine;

   assign busy = 1'b0;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      phase0_ff <= req_elbow_angle_phase;
      arg_ff[0] <= '{w1: req_shoulder_velocity, w2: req_elbow_velocity,
                     a1: req_shoulder_acceleration, a2: req_elbow_acceleration};
      for (int i = 1; i <= ARG_DELAY; i++) begin
         arg_ff[i] <= arg_ff[i-1];
      end
   end

   ffd_phase #(
      .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
   ) u_phase (
      .clock(clock), .reset(reset),
      .valid_in(valid0_ff), .phase_in(phase0_ff),
      .valid_out(angle_valid), .angle_out(angle)
   );

   ffd_trig u_sin (
      .clock(clock), .reset(reset),
      .valid_in(angle_valid), .angle_in(angle),
      .valid_out(sin_valid), .sine_out(sine)
   );

   // cosine as sine a quarter turn ahead
   ffd_trig u_cos (
      .clock(clock), .reset(reset),
      .valid_in(angle_valid), .angle_in(angle + 32'h4000_0000),
      .valid_out(cos_valid), .sine_out(cosine)
   );

   ffd_sum u_sum (
      .clock(clock), .reset(reset),
      .valid_in(sin_valid & cos_valid),
      .sine_in(sine), .cosine_in(cosine),
      .arg_in(arg_ff[ARG_DELAY]),
      .valid_out(rsp_valid),
      .shoulder_out(rsp_shoulder_drive),
      .elbow_out(rsp_elbow_drive),
      .clipped_out(rsp_clipped)
   );

endmodule

// ----- test/two_link_arm_feedforward_drive_checker.sv -----
module two_link_arm_feedforward_drive_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [15:0]        req_elbow_angle_phase,
   input  logic signed [15:0] req_shoulder_velocity,
   input  logic signed [15:0] req_elbow_velocity,
   input  logic signed [15:0] req_shoulder_acceleration,
   input  logic signed [15:0] req_elbow_acceleration,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_shoulder_drive,
   input  logic signed [15:0] rsp_elbow_drive,
   input  logic               rsp_clipped,
   output int                 mismatches,
   output int                 drives_pending,
   output int                 drives_checked,
   output int                 clipped_seen
);
   import ffd_pkg::*;

   typedef struct {
      logic signed [15:0] shoulder;
      logic signed [15:0] elbow;
      logic               clip;
   } drive_type;

   drive_type expected_drives[$];

   // Q16 sine of a Q32-turn angle: quadrant fold, odd series in Horner form
   function automatic longint sine_q16(input longint unsigned ang);
      longint unsigned quad, r, f2, p, s;
      quad = (ang >> 30) & 3;
      r = ang & 64'h3FFF_FFFF;
      if (quad[0]) r = 64'h4000_0000 - r;
      f2 = (r * r) >> 30;
      p = 64'(S9);
      p = 64'(S7) - ((f2 * p) >> 30);
      p = 64'(S5) - ((f2 * p) >> 30);
      p = 64'(S3) - ((f2 * p) >> 30);
      p = 64'(S1) - ((f2 * p) >> 30);
      s = (((r * p) >> 30) + (64'd1 << 13)) >> 14;
      if (s > 65536) s = 65536;
      return quad[1] ? -longint'(s) : longint'(s);
   endfunction

   function automatic longint direction(input longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   // Truncate Q44 sum toward zero, then saturate to 16 bits
   function automatic logic signed [15:0] to_counts(input longint acc, inout logic clip);
      longint d;
      d = acc / (longint'(1) <<< 44);
      if (d > 32767) begin
         clip = 1'b1;
         d = 32767;
      end else if (d < -32768) begin
         clip = 1'b1;
         d = -32768;
      end
      return d[15:0];
   endfunction

   function automatic drive_type arm_drive(input logic [15:0] phase,
         input logic signed [15:0] w1_in, input logic signed [15:0] w2_in,
         input logic signed [15:0] a1_in, input logic signed [15:0] a2_in);
      drive_type r;
      longint unsigned idx, ang;
      longint w1, w2, a1, a2, sn, cs, p12, p22, p11, acc1, acc2;
      logic clip;
      w1 = w1_in; w2 = w2_in; a1 = a1_in; a2 = a2_in;
      idx = (64'(phase) * DEF_SINE_ENTRIES) >> 16;
      ang = (idx << 32) / DEF_SINE_ENTRIES;
      sn = sine_q16(ang & 64'hFFFF_FFFF);
      cs = sine_q16((ang + 64'h4000_0000) & 64'hFFFF_FFFF);
      p12 = (w1 * w2 * sn) / 65536;
      p22 = (w2 * w2 * sn) / 65536;
      p11 = (w1 * w1 * sn) / 65536;
      acc1 = SH_A1 * a1 + SH_A1C * (cs * a1) + SH_A2 * a2 + SH_A2C * (cs * a2)
           + SH_VEL * w1 + SH_FRIC * direction(w1) - 2 * SH_SIN * p12 - SH_SIN * p22;
      acc2 = EL_A1 * a1 + EL_A1C * (cs * a1) + EL_A2 * a2
           + EL_VEL * w2 + EL_FRIC * direction(w2) + EL_SIN * p11;
      clip = 1'b0;
      r.shoulder = to_counts(acc1, clip);
      r.elbow = to_counts(acc2, clip);
      r.clip = clip;
      return r;
   endfunction

   initial begin
      mismatches = 0;
      drives_checked = 0;
      clipped_seen = 0;
   end

   assign drives_pending = expected_drives.size();

   // Predict on each accepted command, compare each response transaction
   always @(posedge clock) begin
      drive_type exp_d;
      if (!reset && rsp_valid) begin
         if (expected_drives.size() == 0) begin
            $display("%0t: unexpected response sd=%0d ed=%0d clip=%0b", $time,
                     rsp_shoulder_drive, rsp_elbow_drive, rsp_clipped);
            mismatches++;
         end else begin
            exp_d = expected_drives.pop_front();
            drives_checked++;
            if (exp_d.clip) clipped_seen++;
            if (rsp_shoulder_drive !== exp_d.shoulder) begin
               $display("%0t: shoulder_drive expected %0d actual %0d", $time,
                        exp_d.shoulder, rsp_shoulder_drive);
               mismatches++;
            end
            if (rsp_elbow_drive !== exp_d.elbow) begin
               $display("%0t: elbow_drive expected %0d actual %0d", $time,
                        exp_d.elbow, rsp_elbow_drive);
               mismatches++;
            end
            if (rsp_clipped !== exp_d.clip) begin
               $display("%0t: clipped expected %0b actual %0b", $time,
                        exp_d.clip, rsp_clipped);
               mismatches++;
            end
         end
      end
      if (!reset && start && !busy)
         expected_drives = {expected_drives, arm_drive(req_elbow_angle_phase,
            req_shoulder_velocity, req_elbow_velocity,
            req_shoulder_acceleration, req_elbow_acceleration)};
   end
endmodule

// ----- test/tb_two_link_arm_feedforward_drive.sv -----
module tb_two_link_arm_feedforward_drive;
   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [15:0]        phase;
   logic signed [15:0] w1, w2, a1, a2;
   logic               rsp_valid;
   logic signed [15:0] sd, ed;
   logic               clipped;
   int                 mismatches, pending, checked, clip_count, sent;

   two_link_arm_feedforward_drive dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_elbow_angle_phase(phase), .req_shoulder_velocity(w1),
      .req_elbow_velocity(w2), .req_shoulder_acceleration(a1),
      .req_elbow_acceleration(a2), .rsp_valid(rsp_valid),
      .rsp_shoulder_drive(sd), .rsp_elbow_drive(ed), .rsp_clipped(clipped)
   );

   two_link_arm_feedforward_drive_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_elbow_angle_phase(phase), .req_shoulder_velocity(w1),
      .req_elbow_velocity(w2), .req_shoulder_acceleration(a1),
      .req_elbow_acceleration(a2), .rsp_valid(rsp_valid),
      .rsp_shoulder_drive(sd), .rsp_elbow_drive(ed), .rsp_clipped(clipped),
      .mismatches(mismatches), .drives_pending(pending),
      .drives_checked(checked), .clipped_seen(clip_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the pipeline hangs
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   // One command transaction, with random idle cycles ahead of it
   task automatic send_cmd(input logic [15:0] p, input logic [15:0] v1,
         input logic [15:0] v2, input logic [15:0] c1, input logic [15:0] c2,
         input int idle_pct);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      phase <= p; w1 <= v1; w2 <= v2; a1 <= c1; a2 <= c2;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   // Mostly moderate magnitudes so drives stay in range; some full range
   function automatic logic [15:0] pick(input int unsigned mag);
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel < 3) return 16'($urandom);
      if (sel == 3) return 16'(0);
      return 16'($signed($urandom_range(2 * mag)) - $signed(mag));
   endfunction

   initial begin
      int idle;
      logic [15:0] extremes[6];
      extremes = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h0000, 16'h00C0};
      sent = 0;
      reset = 1'b1;
      start = 1'b0;
      phase = '0; w1 = '0; w2 = '0; a1 = '0; a2 = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: quadrant angles, angle between entries, zero speed, extremes
      send_cmd(16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
      send_cmd(16'h4000, 16'sd1024, -16'sd1024, 16'sd256, -16'sd256, 0);
      send_cmd(16'h8000, -16'sd1, 16'sd1, 16'sd0, 16'sd0, 0);
      send_cmd(16'hC000, 16'sd1, -16'sd1, 16'sd0, 16'sd0, 0);
      send_cmd(16'hFFFF, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 0);
      send_cmd(16'h003F, 16'sd500, 16'sd500, 16'sd100, 16'sd100, 0);
      send_cmd(16'h0040, 16'sd500, 16'sd500, 16'sd100, 16'sd100, 0);
      send_cmd(16'h2000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
      send_cmd(16'hA000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
      send_cmd(16'h6000, 16'h7FFF, 16'h8000, 16'sd0, 16'sd0, 0);
      foreach (extremes[i])
         send_cmd(16'($urandom), extremes[i], extremes[5 - i], extremes[(i + 2) % 6],
                  extremes[(i + 4) % 6], 0);

      // Random: sender idles sometimes, then often, then never
      for (int n = 0; n < 600; n++) begin
         idle = (n < 200) ? 34 : ((n < 400) ? 80 : 0);
         if ((n % 50) < 10) idle = 0;
         send_cmd(16'($urandom), pick(3000), pick(3000), pick(2000), pick(2000), idle);
      end
      @(negedge clock);
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("Sent %0d commands across all angle quadrants and sign cases;", sent);
      $display("checked %0d drive responses, %0d of them saturated.", checked, clip_count);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
